>>> hw/rtl/asssm_pkg.sv
// Shared types and constants for the alternating-sign subsequence sum block.
`default_nettype none

package asssm_pkg;

    localparam int SAMPLE_W = 18;
    localparam int RES_W    = 24;
    localparam int CFG_W    = 7;

    // Control broadcast from the sequencer to every cell of the row.
    typedef struct packed {
        logic upd;    // an item is accepted this cycle
        logic first;  // that item is the first of its array
        logic live;   // the skip registers hold real sums
        logic load;   // capture the clamped best sum of each cell
        logic shift;  // move the captured sums one cell toward cell zero
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> hw/rtl/alternating_sign_subseq_max_sum_top.sv
// Top level: sequencer, configuration register and the row of length-bound cells.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------------
//  input    | i_in_valid / o_in_ready      | i_sample, i_is_last
//  result   | o_out_valid / i_out_ready    | o_best_sum
//  config   | i_cfg_we (no wait)           | i_cfg_wdata (max_len)
//
// An item not marked last is taken while in S_RUN; all cells update together.
// A last item is followed by a capture state, shift states that walk the sum of
// cell max_len - 1 (max_len clamped to 1 .. MAX_LEN) down the readout chain to
// cell zero, and a write of the result to the output register; input waits
// until that write is done.
// The write stalls while the output register is still full.
// Reset is synchronous and active low; max_len resets to 1.
`default_nettype none

module alternating_sign_subseq_max_sum_top #(
    parameter int MAX_LEN = 64
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire signed [asssm_pkg::SAMPLE_W-1:0] i_sample,
    input  wire                                  i_is_last,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic       [asssm_pkg::RES_W-1:0]    o_best_sum,
    input  wire                                  i_cfg_we,
    input  wire        [asssm_pkg::CFG_W-1:0]    i_cfg_wdata
);
    import asssm_pkg::*;

    localparam int SW = SAMPLE_W + 1 + $clog2(MAX_LEN + 1);
    localparam int CW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = ($clog2(MAX_LEN + 1) > CFG_W) ? $clog2(MAX_LEN + 1) : CFG_W;

    typedef enum logic [1:0] {
        S_RUN,
        S_LOAD,
        S_SHIFT
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_cnt;
    logic               r_seen;
    logic               r_live;
    logic [CFG_W-1:0]   r_max_len;
    logic               r_out_valid;
    logic [RES_W-1:0]   r_best_sum;

    logic [LW-1:0]      len_ext;
    logic [CW-1:0]      len_m1;
    logic               accept;
    logic               out_free;
    logic               out_load;
    t_cell_ctl          ctl;

    logic signed [SW-1:0] neg_hand [MAX_LEN];
    logic signed [SW-1:0] pos_hand [MAX_LEN];
    logic [RES_W-1:0]     res_chain [MAX_LEN];

    // A bound of zero acts as one, a bound beyond the row as the full row.
    assign len_ext = LW'(r_max_len);
    always_comb begin
        if (len_ext == '0) begin
            len_m1 = '0;
        end else if (len_ext > LW'(MAX_LEN)) begin
            len_m1 = CW'(MAX_LEN - 1);
        end else begin
            len_m1 = CW'(len_ext - LW'(1));
        end
    end

    assign o_in_ready  = (r_state == S_RUN);
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign out_load    = (r_state == S_SHIFT) && (r_cnt == '0) && out_free;
    assign o_out_valid = r_out_valid;
    assign o_best_sum  = r_best_sum;

    assign ctl.upd   = accept;
    assign ctl.first = !r_seen;
    assign ctl.live  = r_live;
    assign ctl.load  = (r_state == S_LOAD);
    assign ctl.shift = (r_state == S_SHIFT) && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_cnt       <= '0;
            r_seen      <= 1'b0;
            r_live      <= 1'b0;
            r_max_len   <= CFG_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_RUN: begin
                    if (accept) begin
                        r_seen <= 1'b1;
                        if (r_seen) begin
                            r_live <= 1'b1;
                        end
                        if (i_is_last) begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    // The cells capture their sums now; the array state is done.
                    r_seen  <= 1'b0;
                    r_live  <= 1'b0;
                    r_cnt   <= len_m1;
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    if (r_cnt != '0) begin
                        r_cnt <= r_cnt - CW'(1);
                    end else if (out_free) begin
                        r_best_sum  <= res_chain[0];
                        r_state     <= S_RUN;
                    end
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase
        end
    end

    for (genvar gi = 0; gi < MAX_LEN; gi++) begin : g_cell
        logic signed [SW-1:0] neg_in, pos_in;
        logic [RES_W-1:0]     res_in;

        if (gi == 0) begin : g_head
            assign neg_in = '0;
            assign pos_in = '0;
        end else begin : g_body
            assign neg_in = neg_hand[gi-1];
            assign pos_in = pos_hand[gi-1];
        end

        if (gi == MAX_LEN - 1) begin : g_tail
            assign res_in = '0;
        end else begin : g_mid
            assign res_in = res_chain[gi+1];
        end

        asssm_cell #(
            .SW(SW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (ctl),
            .i_sample (i_sample),
            .i_neg_in (neg_in),
            .i_pos_in (pos_in),
            .o_neg_out(neg_hand[gi]),
            .o_pos_out(pos_hand[gi]),
            .i_res_in (res_in),
            .o_res    (res_chain[gi])
        );
    end

`ifndef ASSERT_OFF
    a_last_goes_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_is_last) |=> (r_state == S_LOAD))
        else $error("last item did not start the readout");

    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |=> (!r_seen && !r_live))
        else $error("array state not cleared after capture");

    a_live_needs_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live |-> r_seen)
        else $error("skip sums live before any sample");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_cnt <= len_m1))
        else $error("readout shift count beyond the bound");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/asssm_cell.sv
// One length-bound cell: four best sums, neighbor hand-off and the readout stage.
`default_nettype none

module asssm_cell #(
    parameter int SW = 26
) (
    input  wire                                i_clk,
    input  wire asssm_pkg::t_cell_ctl          i_ctl,
    input  wire signed [asssm_pkg::SAMPLE_W-1:0] i_sample,
    input  wire signed [SW-1:0]                i_neg_in,
    input  wire signed [SW-1:0]                i_pos_in,
    output logic signed [SW-1:0]               o_neg_out,
    output logic signed [SW-1:0]               o_pos_out,
    input  wire        [asssm_pkg::RES_W-1:0]  i_res_in,
    output logic       [asssm_pkg::RES_W-1:0]  o_res
);
    import asssm_pkg::*;

    localparam int XW = (SW > RES_W + 1) ? SW : RES_W + 1;

    logic signed [SW-1:0] r_sn, r_sp, r_tn, r_tp;
    logic        [RES_W-1:0] r_res;
    logic signed [SW-1:0] a_ext;
    logic signed [SW-1:0] base_neg, base_pos;
    logic signed [SW-1:0] best_take, best_skip, best;
    logic signed [XW-1:0] best_ext;
    logic        [RES_W-1:0] best_sat;

    assign a_ext = {{(SW-SAMPLE_W){i_sample[SAMPLE_W-1]}}, i_sample};

    // What the next cell extends: best sum whose last element had a plus
    // sign (for its minus) and a minus sign (for its plus).
    always_comb begin
        o_neg_out = r_tp;
        o_pos_out = r_tn;
        if (i_ctl.live && r_sp > o_neg_out) begin
            o_neg_out = r_sp;
        end
        if (i_ctl.live && r_sn > o_pos_out) begin
            o_pos_out = r_sn;
        end
    end

    // A restart from zero is always allowed.
    assign base_neg = (i_neg_in > 0) ? i_neg_in : '0;
    assign base_pos = (i_pos_in > 0) ? i_pos_in : '0;

    always_comb begin
        best_take = (r_tn > r_tp) ? r_tn : r_tp;
        best_skip = (r_sn > r_sp) ? r_sn : r_sp;
        best      = (i_ctl.live && best_skip > best_take) ? best_skip : best_take;
        best_ext  = XW'(best);
        if (best_ext < 0) begin
            best_sat = '0;
        end else if (best_ext > XW'({RES_W{1'b1}})) begin
            best_sat = '1;
        end else begin
            best_sat = best_ext[RES_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd) begin
            if (i_ctl.first) begin
                r_tn <= -a_ext;
                r_tp <= a_ext;
            end else begin
                r_sn <= (i_ctl.live && r_sn > r_tn) ? r_sn : r_tn;
                r_sp <= (i_ctl.live && r_sp > r_tp) ? r_sp : r_tp;
                r_tn <= base_neg - a_ext;
                r_tp <= base_pos + a_ext;
            end
        end
        if (i_ctl.load) begin
            r_res <= best_sat;
        end else if (i_ctl.shift) begin
            r_res <= i_res_in;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire
